>>> design/ctt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types and constants of the command timeout tracker.
// ----------------------------------------------------------------------------
package ctt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int SCAN_W      = $clog2(TABLE_DEPTH + 1);
  localparam int CNT_W       = 9;

  localparam int FL_RET = 0;
  localparam int FL_REP = 1;
  localparam int FL_EX  = 2;

  typedef enum logic [2:0] {
    ACT_START = 3'd0,
    ACT_END   = 3'd1,
    ACT_AGENT = 3'd2,
    ACT_TICK  = 3'd3,
    ACT_QUERY = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_TIMEOUT = 2'd0,
    CFG_SLOW    = 2'd1,
    CFG_AGENT   = 2'd2,
    CFG_MAX     = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ELAP,
    S_APPLY,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [21:0] process;
    logic [21:0] thread;
    logic [47:0] send_time;
    logic [47:0] total_time;
    logic [31:0] call_count;
    logic [15:0] agent_count;
    logic [31:0] last_command;
    logic [2:0]  flags;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    state_t             state;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               ev_vld;
    logic [IDX_W-1:0]   ev_idx;
  } ctrl_t;

  typedef struct packed {
    logic hit;
    logic out_free;
  } seq_stat_t;

endpackage

>>> design/ctt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ctt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/ctt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_ctrl
// Sequencer that walks the entry table one read per cycle.
// ----------------------------------------------------------------------------
module ctt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  ctt_pkg::seq_stat_t stat,
  output ctt_pkg::ctrl_t     ctrl
);
  import ctt_pkg::*;

  state_t             state_r, state_nxt;
  logic [SCAN_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic               ev_vld_r;
  logic [IDX_W-1:0]   ev_idx_r;
  logic               rd_en;
  logic               scan_done;

  assign rd_en     = (state_r == S_SCAN) && (scan_idx_r < SCAN_W'(TABLE_DEPTH));
  assign scan_done = (state_r == S_SCAN) && !rd_en && !ev_vld_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_SCAN;
      S_SCAN:  if (stat.hit || scan_done) state_nxt = S_ELAP;
      S_ELAP:  state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_FIN;
      S_FIN:   if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    scan_idx_nxt = scan_idx_r;
    if (state_r == S_IDLE) begin
      scan_idx_nxt = '0;
    end else if (rd_en) begin
      scan_idx_nxt = scan_idx_r + SCAN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      scan_idx_r <= '0;
      ev_vld_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
      ev_vld_r   <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    ev_idx_r <= scan_idx_r[IDX_W-1:0];
  end

  always_comb begin
    ctrl.state   = state_r;
    ctrl.rd_en   = rd_en;
    ctrl.rd_addr = scan_idx_r[IDX_W-1:0];
    ctrl.ev_vld  = ev_vld_r && (state_r == S_SCAN);
    ctrl.ev_idx  = ev_idx_r;
  end

endmodule

>>> design/command_timeout_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_timeout_tracker_top
// Table of outstanding commands per thread with timeout and slow tracking.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries one action in in_tuser (start, end,
// agent call, tick or query) and the caller's key, command and time in
// in_tdata. Every input transaction yields exactly one result transaction on
// the out_ channel. Configuration registers are to be written through
// cfg_valid, cfg_addr and cfg_data only while the block is idle; the user
// must keep to this, since the block itself does not enforce it (cfg_ready is
// always high). The sequencer reads the entry RAM one entry per cycle
// through its single read port. A start, end, agent call or query stops at
// the first matching entry; a tick or a miss walks all TABLE_DEPTH entries.
// After the scan the sequencer passes through S_ELAP and S_APPLY to S_FIN,
// where the result is loaded. in_tready is low until then, so the next input
// transaction is taken in the cycle after the load at the earliest.
// The result sits in an output register, so a new input transaction is taken
// while the previous result still waits; a stalled receiver only holds the
// sequencer in its final state before the next result is loaded.
// Reset clears all valid bits, the entry count and the registers to their
// defaults; the RAM contents are never cleared, only the valid bits matter.
// ----------------------------------------------------------------------------
module command_timeout_tracker_top (
  input  logic         clk,
  input  logic         rst_n,
  // Input: process_id[21:0], thread_id[43:22], command_id[75:44],
  // now_us[123:76], exempt[124], zero fill above.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,
  // in_tuser: action[2:0]
  input  logic [2:0]   in_tuser,
  // Output: status[1:0], reported[2], entries_in_use[11:3],
  // start_timer[12], removed_count[21:13], new_timeouts[30:22],
  // slow_count[39:31], dump_request[40], keep_ticking[41], zero fill above.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_data
);
  import ctt_pkg::*;

  // Configuration registers.
  logic [31:0] timeout_r;
  logic [31:0] slow_r;
  logic [15:0] agent_lim_r;
  logic [8:0]  max_ent_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= 32'd25000000;
      slow_r      <= 32'd1000000;
      agent_lim_r <= 16'd250;
      max_ent_r   <= 9'd200;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_TIMEOUT: timeout_r   <= cfg_data;
        CFG_SLOW:    slow_r      <= cfg_data;
        CFG_AGENT:   agent_lim_r <= cfg_data[15:0];
        CFG_MAX:     max_ent_r   <= cfg_data[8:0];
        default:     ;
      endcase
    end
  end

  // Sequencer.
  ctrl_t     ctrl;
  seq_stat_t stat;
  logic      in_acc;
  logic      out_tvalid_r;
  logic [47:0] out_tdata_r;

  assign in_tready = (ctrl.state == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  ctt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Latched transaction.
  logic [2:0]  act_r;
  logic [21:0] pid_r;
  logic [21:0] tid_r;
  logic [31:0] cmd_r;
  logic [47:0] now_r;
  logic        ex_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_tuser;
      pid_r <= in_tdata[21:0];
      tid_r <= in_tdata[43:22];
      cmd_r <= in_tdata[75:44];
      now_r <= in_tdata[123:76];
      ex_r  <= in_tdata[124];
    end
  end

  // Entry storage: valid bits in flops, payload in RAM.
  logic [TABLE_DEPTH-1:0] valid_r;
  logic                   valid_rd_r;
  logic [CNT_W-1:0]       count_r;
  entry_t                 rd_data;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_wa;
  entry_t                 ram_wd;
  logic [ENTRY_W-1:0]     rd_raw;

  ctt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .raddr (ctrl.rd_addr),
    .rdata (rd_raw)
  );

  assign rd_data = entry_t'(rd_raw);

  // The valid bit is read alongside the RAM so both arrive in the same cycle.
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      valid_rd_r <= valid_r[ctrl.rd_addr];
    end
  end

  // Per-entry evaluation during the scan.
  logic        ev_live;
  logic        key_match;
  logic        ev_hit;
  logic [47:0] ev_el;
  logic        ev_ret;
  logic        ev_tmo;
  logic        ev_slow;
  logic        is_tick;

  assign is_tick = (act_r == ACT_TICK);
  assign ev_live = ctrl.ev_vld && valid_rd_r;

  always_comb begin
    case (act_r)
      ACT_START, ACT_END, ACT_AGENT:
        key_match = (rd_data.process == pid_r) && (rd_data.thread == tid_r);
      ACT_QUERY: key_match = !ex_r && (rd_data.thread == tid_r);
      default:   key_match = 1'b0;
    endcase
  end

  assign ev_hit  = ev_live && key_match;
  assign ev_el   = now_r - rd_data.send_time;
  assign ev_ret  = ev_live && is_tick && rd_data.flags[FL_RET];
  assign ev_tmo  = ev_live && is_tick && !rd_data.flags[FL_RET]
                   && (ev_el > {16'd0, timeout_r}) && !rd_data.flags[FL_REP];
  assign ev_slow = ev_live && is_tick && !rd_data.flags[FL_RET] && !ev_tmo
                   && (ev_el > {16'd0, slow_r});

  assign stat.hit      = ev_hit;
  assign stat.out_free = !out_tvalid_r || out_tready;

  // Hit and free-slot capture, result accumulation.
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  entry_t           hit_data_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;
  logic [47:0]      el_r;
  logic [1:0]       res_status_r;
  logic             res_rep_r;
  logic             res_tstart_r;
  logic [CNT_W-1:0] res_removed_r;
  logic [CNT_W-1:0] res_newto_r;
  logic [CNT_W-1:0] res_slow_r;
  logic             res_dump_r;
  logic             res_keep_r;
  logic             table_full;
  logic             do_insert;

  assign table_full = (count_r >= max_ent_r) || (count_r >= CNT_W'(TABLE_DEPTH))
                      || !free_found_r;
  assign do_insert  = (ctrl.state == S_APPLY) && (act_r == ACT_START)
                      && !hit_r && !table_full;

  // The elapsed time of the hit entry comes from the scan subtractor.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
    end else if (ctrl.state == S_SCAN) begin
      if (ev_hit) begin
        hit_r      <= 1'b1;
        hit_idx_r  <= ctrl.ev_idx;
        hit_data_r <= rd_data;
        el_r       <= ev_el;
      end
      if (ctrl.ev_vld && !valid_rd_r && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= ctrl.ev_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_status_r  <= ST_OK;
      res_rep_r     <= 1'b0;
      res_tstart_r  <= 1'b0;
      res_removed_r <= '0;
      res_newto_r   <= '0;
      res_slow_r    <= '0;
      res_dump_r    <= 1'b0;
      res_keep_r    <= 1'b0;
    end else if (ctrl.state == S_SCAN) begin
      if (ev_ret)  res_removed_r <= res_removed_r + CNT_W'(1);
      if (ev_tmo)  res_newto_r   <= res_newto_r + CNT_W'(1);
      if (ev_tmo && !rd_data.flags[FL_EX]) res_dump_r <= 1'b1;
      if (ev_slow) res_slow_r    <= res_slow_r + CNT_W'(1);
    end else if (ctrl.state == S_APPLY) begin
      case (act_r)
        ACT_START: begin
          if (!hit_r && table_full) res_status_r <= ST_FULL;
          if (do_insert && count_r == '0) res_tstart_r <= 1'b1;
        end
        ACT_END, ACT_AGENT: begin
          if (!hit_r) res_status_r <= ST_NOT_FOUND;
        end
        ACT_TICK: res_keep_r <= (count_r != '0);
        ACT_QUERY: begin
          if (!hit_r) begin
            res_status_r <= ST_NOT_FOUND;
          end else begin
            res_rep_r <= hit_data_r.flags[FL_REP]
                         || (hit_data_r.agent_count > agent_lim_r);
          end
        end
        default: ;
      endcase
    end
  end

  // Valid bits and entry count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (ev_ret) begin
      valid_r[ctrl.ev_idx] <= 1'b0;
      if (count_r != '0) count_r <= count_r - CNT_W'(1);
    end else if (do_insert) begin
      valid_r[free_idx_r] <= 1'b1;
      count_r <= count_r + CNT_W'(1);
    end
  end

  // RAM write port.
  always_comb begin
    ram_we = 1'b0;
    ram_wa = ctrl.ev_idx;
    ram_wd = rd_data;
    if (ctrl.state == S_SCAN) begin
      if (ev_tmo) begin
        ram_we = 1'b1;
        ram_wd.flags[FL_REP] = 1'b1;
      end
    end else if (ctrl.state == S_APPLY) begin
      ram_wa = hit_idx_r;
      ram_wd = hit_data_r;
      case (act_r)
        ACT_START: begin
          ram_wd.send_time    = now_r;
          ram_wd.agent_count  = '0;
          ram_wd.last_command = cmd_r;
          ram_wd.flags        = {ex_r, 2'b00};
          if (hit_r) begin
            ram_we = 1'b1;
            ram_wd.call_count = hit_data_r.call_count + 32'd1;
          end else if (do_insert) begin
            ram_we            = 1'b1;
            ram_wa            = free_idx_r;
            ram_wd.process    = pid_r;
            ram_wd.thread     = tid_r;
            ram_wd.total_time = '0;
            ram_wd.call_count = 32'd1;
          end
        end
        ACT_END: begin
          ram_we = hit_r;
          ram_wd.total_time = hit_data_r.total_time + el_r;
          ram_wd.flags[FL_RET] = 1'b1;
        end
        ACT_AGENT: begin
          ram_we = hit_r;
          ram_wd.send_time = now_r;
          if (hit_data_r.agent_count != 16'hFFFF) begin
            ram_wd.agent_count = hit_data_r.agent_count + 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctrl.state == S_FIN && stat.out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.state == S_FIN && stat.out_free) begin
      out_tdata_r <= {6'd0, res_keep_r, res_dump_r, res_slow_r, res_newto_r,
                      res_removed_r, res_tstart_r, count_r, res_rep_r,
                      res_status_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

>>> design/ctt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_checker
// Port-level checks of the command timeout tracker.
// ----------------------------------------------------------------------------
module ctt_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [47:0]  out_tdata
);
  import ctt_pkg::*;

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // After an accepted transaction the sequencer stays busy for a while.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("input taken while busy");

  // Status is never the unused code.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("bad status code");

  // Entry count never exceeds the table.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[11:3] <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

endmodule

bind command_timeout_tracker_top ctt_checker u_ctt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/sv/command_timeout_tracker_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_timeout_tracker_top_tb
// Self-checking bench for the outstanding-command tracker.
// ----------------------------------------------------------------------------
// A scoreboard object keeps its own copy of the command table and of the
// registers. It predicts one result per accepted input transaction and checks
// every result transaction field by field, oldest first. The stimulus begins
// with directed items covering the field extremes, each action, unknown
// actions and time wrap-around. It then runs several register settings with
// random traffic on a small pool of keys, a full-table fill and a run of
// agent calls that pushes a thread past the agent call limit. Both stream
// sides idle at random.
// ----------------------------------------------------------------------------
module command_timeout_tracker_top_tb;
  import ctt_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    bit [1:0] status;
    bit       reported;
    bit [8:0] entries_in_use;
    bit       start_timer;
    bit [8:0] removed_count;
    bit [8:0] new_timeouts;
    bit [8:0] slow_count;
    bit       dump_request;
    bit       keep_ticking;
  } tracker_result_t;

  // The scoreboard holds a shadow of the table and the queue of results that
  // the block still owes.
  class tracker_scoreboard;
    bit        used[TABLE_DEPTH];
    bit [21:0] proc_id[TABLE_DEPTH];
    bit [21:0] thr_id[TABLE_DEPTH];
    bit [47:0] sent_at[TABLE_DEPTH];
    bit [47:0] total_us[TABLE_DEPTH];
    bit [31:0] calls[TABLE_DEPTH];
    bit [15:0] agent_calls[TABLE_DEPTH];
    bit [31:0] last_cmd[TABLE_DEPTH];
    bit [2:0]  flags[TABLE_DEPTH];
    int unsigned in_use;
    bit [31:0] timeout_us;
    bit [31:0] slow_us;
    bit [15:0] agent_limit;
    bit [8:0]  max_entries;
    tracker_result_t owed_q[$];
    int unsigned errors;

    function new();
      foreach (used[i]) used[i] = 0;
      in_use      = 0;
      timeout_us  = 32'd25000000;
      slow_us     = 32'd1000000;
      agent_limit = 16'd250;
      max_entries = 9'd200;
      errors      = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, bit [31:0] value);
      case (idx)
        CFG_TIMEOUT: timeout_us = value;
        CFG_SLOW:    slow_us = value;
        CFG_AGENT:   agent_limit = value[15:0];
        CFG_MAX:     max_entries = value[8:0];
        default: ;
      endcase
    endfunction

    function int find_key(bit [21:0] pid, bit [21:0] tid);
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (used[i] && proc_id[i] == pid && thr_id[i] == tid) return i;
      return -1;
    endfunction

    function void note_item(bit [2:0] action, bit [21:0] pid, bit [21:0] tid,
                            bit [31:0] cmd, bit [47:0] now, bit ex);
      tracker_result_t r;
      int k;
      int slot;
      bit [47:0] elapsed;
      r = '{default: 0};
      case (action)
        ACT_START: begin
          k = find_key(pid, tid);
          if (k >= 0) begin
            sent_at[k] = now;
            calls[k] = calls[k] + 1;
            flags[k] = ex ? (3'b1 << FL_EX) : 3'b0;
            last_cmd[k] = cmd;
            agent_calls[k] = 0;
          end else if (in_use >= max_entries || in_use >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            slot = 0;
            while (slot < TABLE_DEPTH && used[slot]) slot++;
            if (slot >= TABLE_DEPTH) begin
              r.status = ST_FULL;
            end else begin
              used[slot] = 1;
              proc_id[slot] = pid;
              thr_id[slot] = tid;
              sent_at[slot] = now;
              total_us[slot] = 0;
              calls[slot] = 1;
              agent_calls[slot] = 0;
              last_cmd[slot] = cmd;
              flags[slot] = ex ? (3'b1 << FL_EX) : 3'b0;
              in_use++;
              if (in_use == 1) r.start_timer = 1;
            end
          end
        end
        ACT_END: begin
          k = find_key(pid, tid);
          if (k < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            total_us[k] = total_us[k] + (now - sent_at[k]);
            flags[k][FL_RET] = 1;
          end
        end
        ACT_AGENT: begin
          k = find_key(pid, tid);
          if (k < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            sent_at[k] = now;
            if (agent_calls[k] != 16'hFFFF) agent_calls[k]++;
          end
        end
        ACT_TICK: begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!used[i]) continue;
            if (flags[i][FL_RET]) begin
              used[i] = 0;
              if (in_use > 0) in_use--;
              r.removed_count++;
              continue;
            end
            elapsed = now - sent_at[i];
            if (elapsed > {16'b0, timeout_us} && !flags[i][FL_REP]) begin
              flags[i][FL_REP] = 1;
              r.new_timeouts++;
              if (!flags[i][FL_EX]) r.dump_request = 1;
            end else if (elapsed > {16'b0, slow_us}) begin
              r.slow_count++;
            end
          end
          r.keep_ticking = in_use > 0;
        end
        ACT_QUERY: begin
          r.status = ST_NOT_FOUND;
          if (!ex) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
              if (used[i] && thr_id[i] == tid) begin
                r.status = ST_OK;
                r.reported = flags[i][FL_REP] || agent_calls[i] > agent_limit;
                break;
              end
            end
          end
        end
        default: ;
      endcase
      r.entries_in_use = in_use[8:0];
      owed_q.push_back(r);
    endfunction

    function void compare(string field, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, actual %0d", field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(bit [47:0] d);
      tracker_result_t e;
      if (owed_q.size() == 0) begin
        $error("result transaction with no expected result: %h", d);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      compare("status", e.status, d[1:0]);
      compare("reported", e.reported, d[2]);
      compare("entries_in_use", e.entries_in_use, d[11:3]);
      compare("start_timer", e.start_timer, d[12]);
      compare("removed_count", e.removed_count, d[21:13]);
      compare("new_timeouts", e.new_timeouts, d[30:22]);
      compare("slow_count", e.slow_count, d[39:31]);
      compare("dump_request", e.dump_request, d[40]);
      compare("keep_ticking", e.keep_ticking, d[41]);
      compare("zero fill", 0, d[47:42]);
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic [2:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [47:0]  out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_addr;
  logic [31:0]  cfg_data;

  tracker_scoreboard sb;
  // When set, neither side idles; used for stretches without gaps and for the
  // agent-call run.
  bit          quiet;
  bit [47:0]   clock_us;
  int unsigned time_step;
  int unsigned idle_cycles;
  bit [21:0]   pid_pool[4] = '{22'd0, 22'd1, 22'h2AAAAA, 22'h3FFFFF};
  bit [21:0]   tid_pool[4] = '{22'd0, 22'd5, 22'h155555, 22'h3FFFFF};

  command_timeout_tracker_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // The watchdog ends the run once no channel has moved a transaction for a
  // long stretch. The slowest item is a full table scan plus both idle gaps,
  // so the limit leaves a wide margin.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic int unsigned draw_gap();
    return quiet ? 0 : $urandom_range(0, 18);
  endfunction

  // Sends one input transaction. The valid stays high after acceptance so
  // that a back-to-back item does not drop and raise it in the same step.
  task automatic send_item(bit [2:0] action, bit [21:0] pid, bit [21:0] tid,
                           bit [31:0] cmd, bit [47:0] now, bit ex);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= action;
    in_tdata  <= {3'b0, ex, now, cmd, tid, pid};
    do @(posedge clk); while (!in_tready);
    sb.note_item(action, pid, tid, cmd, now, ex);
    @(negedge clk);
  endtask

  // Registers are written only once the block has delivered every result.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.owed_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
  endtask

  // The valid is dropped for one cycle so that the next write raises it in a
  // later step.
  task automatic write_reg(cfg_idx_t idx, bit [31:0] value);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(bit [31:0] tmo, bit [31:0] slw, bit [15:0] lim,
                               bit [8:0] maxe);
    settle();
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_SLOW, slw);
    write_reg(CFG_AGENT, {16'b0, lim});
    write_reg(CFG_MAX, {23'b0, maxe});
  endtask

  // Random traffic: mostly well-formed operations on a small key pool so that
  // starts, ends, agent calls and queries hit live entries, with some items
  // carrying fully random fields and a few unknown actions.
  task automatic random_traffic(int unsigned count);
    bit [2:0]  action;
    bit [21:0] pid;
    bit [21:0] tid;
    int unsigned pick;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 30)      action = ACT_START;
      else if (pick < 50) action = ACT_END;
      else if (pick < 65) action = ACT_AGENT;
      else if (pick < 83) action = ACT_TICK;
      else if (pick < 97) action = ACT_QUERY;
      else                action = 3'($urandom_range(5, 7));
      if ($urandom_range(0, 99) < 85) begin
        pid = pid_pool[$urandom_range(0, 3)];
        tid = tid_pool[$urandom_range(0, 3)];
      end else begin
        pid = 22'($urandom);
        tid = 22'($urandom);
      end
      if ($urandom_range(0, 99) < 4) clock_us = 48'({$urandom, $urandom});
      else clock_us = clock_us + $urandom_range(0, time_step);
      send_item(action, pid, tid, $urandom, clock_us, 1'($urandom_range(0, 1)));
    end
  endtask

  // Result side: an idle gap is drawn for every result transaction.
  initial begin
    @(negedge clk);
    forever begin
      int unsigned gap;
      gap = draw_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata);
      @(negedge clk);
    end
  end

  initial begin
    sb          = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    out_tready  = 1'b0;
    cfg_valid   = 1'b0;
    cfg_addr    = '0;
    cfg_data    = '0;
    quiet       = 0;
    clock_us    = 48'd1000;
    time_step   = 3000000;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed items under the reset register values.
    send_item(ACT_START, 22'h3FFFFF, 22'h3FFFFF, 32'hFFFFFFFF, 48'hFFFFFFFFFFF0, 1);
    send_item(ACT_START, 22'd0, 22'd0, 32'd0, 48'd0, 0);
    send_item(ACT_START, 22'd0, 22'd0, 32'd7, 48'd10, 0);
    send_item(ACT_AGENT, 22'd0, 22'd0, 32'd0, 48'd20, 0);
    send_item(ACT_AGENT, 22'd9, 22'd0, 32'd0, 48'd20, 0);
    send_item(ACT_QUERY, 22'd0, 22'd0, 32'd0, 48'd30, 0);
    send_item(ACT_QUERY, 22'd0, 22'd0, 32'd0, 48'd30, 1);
    send_item(ACT_QUERY, 22'd0, 22'd77, 32'd0, 48'd30, 0);
    // Elapsed time wraps past 2^48 for the first entry.
    send_item(ACT_TICK, 22'd0, 22'd0, 32'd0, 48'd40000000, 0);
    send_item(ACT_QUERY, 22'd5, 22'h3FFFFF, 32'd0, 48'd40000000, 0);
    send_item(ACT_END, 22'h3FFFFF, 22'h3FFFFF, 32'd0, 48'd5, 0);
    // An end of an entry that has already returned still adds time.
    send_item(ACT_END, 22'h3FFFFF, 22'h3FFFFF, 32'd0, 48'd6, 0);
    send_item(ACT_END, 22'd1, 22'd1, 32'd0, 48'd6, 0);
    send_item(ACT_TICK, 22'd0, 22'd0, 32'd0, 48'd2000000, 0);
    send_item(3'd5, 22'h3FFFFF, 22'h3FFFFF, 32'hFFFFFFFF, 48'hFFFFFFFFFFFF, 1);
    send_item(3'd6, 22'd0, 22'd0, 32'd0, 48'd0, 0);
    send_item(3'd7, 22'd0, 22'd0, 32'd0, 48'd0, 1);
    send_item(ACT_END, 22'd0, 22'd0, 32'd0, 48'hFFFFFFFFFFFF, 0);
    send_item(ACT_TICK, 22'd0, 22'd0, 32'd0, 48'hFFFFFFFFFFFF, 0);

    random_traffic(100);

    apply_setting(32'd100, 32'd40, 16'd3, 9'd4);
    time_step = 120;
    random_traffic(200);

    apply_setting(32'd0, 32'd0, 16'd0, 9'd1);
    time_step = 5;
    random_traffic(150);

    // Widest time and agent limits: fill the whole table with distinct keys,
    // one more start than it holds, then end every third entry and tick.
    apply_setting(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 9'd256);
    for (int i = 0; i <= TABLE_DEPTH; i++)
      send_item(ACT_START, i[21:0], 22'h2AAAAA, $urandom, clock_us, i[0]);
    for (int i = 0; i < TABLE_DEPTH; i += 3)
      send_item(ACT_END, i[21:0], 22'h2AAAAA, 32'd0, clock_us + 48'd9, 0);
    send_item(ACT_TICK, 22'd0, 22'd0, 32'd0, clock_us + 48'h100000000, 0);
    time_step = 32'hFFFFFFFF;
    random_traffic(100);

    // A limit of zero entries keeps the table always full.
    apply_setting(32'd500, 32'd200, 16'd1, 9'd0);
    time_step = 400;
    random_traffic(120);

    apply_setting(32'd300, 32'd100, 16'd2, 9'h1FF);
    time_step = 250;
    random_traffic(120);

    // A run of agent calls past the agent call limit, then queries on both
    // sides of the limit.
    apply_setting(32'hFFFFFFFF, 32'hFFFFFFFF, 16'd10, 9'd200);
    send_item(ACT_TICK, 22'd0, 22'd0, 32'd0, 48'd0, 0);
    send_item(ACT_START, 22'd3, 22'd3, 32'd1, 48'd0, 0);
    quiet = 1;
    for (int i = 0; i < 20; i++)
      send_item(ACT_AGENT, 22'd3, 22'd3, 32'd0, 48'd1, 0);
    send_item(ACT_QUERY, 22'd0, 22'd3, 32'd0, 48'd1, 0);
    quiet = 0;
    settle();
    write_reg(CFG_AGENT, 32'd65534);
    send_item(ACT_QUERY, 22'd0, 22'd3, 32'd0, 48'd1, 0);
    random_traffic(50);

    settle();
    repeat (300) @(posedge clk);
    if (sb.owed_q.size() > 0) begin
      $error("%0d expected results never arrived", sb.owed_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
